/* rtl/tcw_pkg.sv */
// tcw_pkg: shared constants, opcodes and sequencer states of the text console writer.
// No dependencies; imported by every module of the block.
package tcw_pkg;

  localparam int COLS_DEF = 80;
  localparam int ROWS_DEF = 25;

  localparam int CHAR_W = 8;
  localparam int ATTR_W = 8;
  localparam int COLOR_W = 4;
  localparam int CELL_W = CHAR_W + ATTR_W;
  localparam int OP_W = 2;
  localparam int RD_ROW_W = 5;
  localparam int RD_COL_W = 7;
  localparam int IDX_W = 1;

  localparam logic [CHAR_W-1:0] BLANK_CHAR = 8'h20;
  localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'h0A;

  localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
  localparam logic [OP_W-1:0] OP_READ = 2'd2;

  localparam logic [IDX_W-1:0] REG_FG = 1'b0;
  localparam logic [IDX_W-1:0] REG_BG = 1'b1;

  localparam logic [COLOR_W-1:0] FG_RESET = 4'd15;
  localparam logic [COLOR_W-1:0] BG_RESET = 4'd0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PUT,
    ST_READ,
    ST_DONE,
    ST_SCROLL,
    ST_DRAIN,
    ST_FILL
  } tcw_state_e;

endpackage

/* rtl/tcw_cell_mem.sv */
// tcw_cell_mem: single-write, single-read cell memory with registered read data.
// Depends on tcw_pkg for the cell width.
module tcw_cell_mem #(
  parameter int DEPTH = tcw_pkg::ROWS_DEF * tcw_pkg::COLS_DEF,
  parameter int AW = $clog2(DEPTH)
) (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [AW-1:0]             waddr_i,
  input  logic [tcw_pkg::CELL_W-1:0] wdata_i,
  input  logic [AW-1:0]             raddr_i,
  output logic [tcw_pkg::CELL_W-1:0] rdata_o
);
  import tcw_pkg::*;

  logic [CELL_W-1:0] mem [DEPTH];
  logic [CELL_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/tcw_ctrl.sv */
// tcw_ctrl: sequencer of the text console writer: cursor, cell address walk for
// scroll and clear, memory port control and the result register. Uses tcw_pkg.
module tcw_ctrl #(
  parameter int COLS = tcw_pkg::COLS_DEF,
  parameter int ROWS = tcw_pkg::ROWS_DEF,
  parameter int AW = $clog2(ROWS * COLS)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [tcw_pkg::ATTR_W-1:0]    attr_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [tcw_pkg::OP_W-1:0]      opcode_i,
  input  logic [tcw_pkg::CHAR_W-1:0]    char_code_i,
  input  logic [tcw_pkg::RD_ROW_W-1:0]  read_row_i,
  input  logic [tcw_pkg::RD_COL_W-1:0]  read_col_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [4:0]                    cursor_row_out_o,
  output logic [6:0]                    cursor_col_out_o,
  output logic [tcw_pkg::CHAR_W-1:0]    cell_char_o,
  output logic [tcw_pkg::ATTR_W-1:0]    cell_attr_o,
  output logic                          mem_we_o,
  output logic [AW-1:0]                 mem_waddr_o,
  output logic [tcw_pkg::CELL_W-1:0]    mem_wdata_o,
  output logic [AW-1:0]                 mem_raddr_o,
  input  logic [tcw_pkg::CELL_W-1:0]    mem_rdata_i
);
  import tcw_pkg::*;

  localparam int NCELLS = ROWS * COLS;
  localparam int RW = $clog2(ROWS);
  localparam int CW = $clog2(COLS + 1);

  tcw_state_e state_q, state_d;
  logic [RW-1:0] row_q, row_d;
  logic [CW-1:0] col_q, col_d;
  logic [AW-1:0] ptr_q, ptr_d;
  logic [AW-1:0] waddr_q, waddr_d;
  logic          wv_q, wv_d;
  logic          put_q, put_d;
  logic [CHAR_W-1:0] ch_q, ch_d;
  logic          in_range_q, in_range_d;

  logic          out_valid_q, out_valid_d;
  logic [4:0]    row_out_q, row_out_d;
  logic [6:0]    col_out_q, col_out_d;
  logic [CHAR_W-1:0] cchar_q, cchar_d;
  logic [ATTR_W-1:0] cattr_q, cattr_d;

  logic accept, is_nl, line_full, last_row, need_nl, scroll_go, ptr_end, load;
  logic [AW-1:0] cur_addr, rd_addr;

  assign in_stall_o = (state_q != ST_IDLE) || (out_valid_q && out_stall_i);
  assign accept = (state_q == ST_IDLE) && in_valid_i && !in_stall_o;
  assign is_nl = (char_code_i == NEWLINE_CHAR);
  assign line_full = (col_q >= CW'(COLS));
  assign last_row = (row_q == RW'(ROWS - 1));
  assign need_nl = is_nl || line_full;
  assign scroll_go = need_nl && last_row;
  assign ptr_end = (ptr_q == AW'(NCELLS - 1));
  assign cur_addr = AW'(row_q) * AW'(COLS) + AW'(col_q);
  assign rd_addr = AW'(read_row_i) * AW'(COLS) + AW'(read_col_i);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (opcode_i)
            OP_WRITE: begin
              if (scroll_go) state_d = ST_SCROLL;
              else if (is_nl) state_d = ST_DONE;
              else state_d = ST_PUT;
            end
            OP_CLEAR: state_d = ST_FILL;
            OP_READ:  state_d = ST_READ;
            default:  state_d = ST_DONE;
          endcase
        end
      end
      ST_PUT:    state_d = ST_IDLE;
      ST_READ:   state_d = ST_IDLE;
      ST_DONE:   state_d = ST_IDLE;
      ST_SCROLL: if (ptr_end) state_d = ST_DRAIN;
      ST_DRAIN:  state_d = ST_FILL;
      ST_FILL: begin
        if (ptr_end) state_d = put_q ? ST_PUT : ST_DONE;
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  // Datapath and memory port control
  always_comb begin
    row_d = row_q;
    col_d = col_q;
    ptr_d = ptr_q;
    put_d = put_q;
    ch_d = ch_q;
    in_range_d = in_range_q;
    wv_d = 1'b0;
    waddr_d = ptr_q - AW'(COLS);
    mem_we_o = 1'b0;
    mem_waddr_o = ptr_q;
    mem_wdata_o = {attr_i, BLANK_CHAR};
    mem_raddr_o = ptr_q;
    load = 1'b0;
    cchar_d = '0;
    cattr_d = '0;
    case (state_q)
      ST_IDLE: begin
        mem_raddr_o = rd_addr;
        if (accept) begin
          ch_d = char_code_i;
          in_range_d = (32'(read_row_i) < ROWS) && (32'(read_col_i) < COLS);
          ptr_d = '0;
          put_d = 1'b0;
          if (opcode_i == OP_WRITE) begin
            put_d = !is_nl;
            ptr_d = AW'(COLS);
            if (need_nl) begin
              col_d = '0;
              if (!last_row) row_d = row_q + RW'(1);
            end
          end
        end
      end
      ST_PUT: begin
        mem_we_o = 1'b1;
        mem_waddr_o = cur_addr;
        mem_wdata_o = {attr_i, ch_q};
        col_d = col_q + CW'(1);
        load = 1'b1;
      end
      ST_READ: begin
        load = 1'b1;
        if (in_range_q) begin
          cchar_d = mem_rdata_i[CHAR_W-1:0];
          cattr_d = mem_rdata_i[CELL_W-1:CHAR_W];
        end
      end
      ST_DONE: load = 1'b1;
      ST_SCROLL: begin
        // read one cell ahead, write it a row up in the next cycle
        wv_d = 1'b1;
        mem_we_o = wv_q;
        mem_waddr_o = waddr_q;
        mem_wdata_o = mem_rdata_i;
        if (!ptr_end) ptr_d = ptr_q + AW'(1);
      end
      ST_DRAIN: begin
        mem_we_o = wv_q;
        mem_waddr_o = waddr_q;
        mem_wdata_o = mem_rdata_i;
        ptr_d = AW'(NCELLS - COLS);
      end
      ST_FILL: begin
        mem_we_o = 1'b1;
        if (!ptr_end) ptr_d = ptr_q + AW'(1);
      end
      default: ;
    endcase
    row_out_d = 5'(row_d);
    col_out_d = 7'(col_d);
    out_valid_d = load || (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      row_q <= '0;
      col_q <= '0;
      wv_q <= 1'b0;
      put_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      row_q <= row_d;
      col_q <= col_d;
      wv_q <= wv_d;
      put_q <= put_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q <= ptr_d;
    waddr_q <= waddr_d;
    ch_q <= ch_d;
    in_range_q <= in_range_d;
    if (load) begin
      row_out_q <= row_out_d;
      col_out_q <= col_out_d;
      cchar_q <= cchar_d;
      cattr_q <= cattr_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign cursor_row_out_o = row_out_q;
  assign cursor_col_out_o = col_out_q;
  assign cell_char_o = cchar_q;
  assign cell_attr_o = cattr_q;

endmodule

/* rtl/text_console_writer.sv */
// text_console_writer: top level of the character-cell text console; holds the
// color registers and joins tcw_ctrl and tcw_cell_mem. Uses tcw_pkg.
//
//   channel | valid      | flow control | payload
//   --------+------------+--------------+---------------------------------------------
//   in      | in_valid_i | in_stall_o   | opcode_i, char_code_i, read_row_i, read_col_i
//   out     | out_valid_o| out_stall_i  | cursor_row_out_o, cursor_col_out_o,
//           |            |              | cell_char_o, cell_attr_o
//   cfg     | cfg_valid_i| cfg_ready_o  | cfg_index_i, cfg_data_i
//
// A character write, read, newline without scroll or no-op passes PUT, READ or DONE, which
// loads the result register. Clear walks the cell memory one cell a cycle in FILL.
// A scroll copies one cell a cycle (SCROLL, DRAIN), then blanks the bottom row (FILL),
// then stores a pending character in PUT or, after a newline, finishes in DONE.
// The single write port of the cell memory sets this pace; one item is in work at a time.
// Reset clears the cursor and loads the default colors; cell contents stay undefined until
// written or cleared.
// A held result blocks the next transfer in; a new item waits while the sequencer is busy
// or the result register is full and stalled.
module text_console_writer #(
  parameter int COLS = tcw_pkg::COLS_DEF,
  parameter int ROWS = tcw_pkg::ROWS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [tcw_pkg::OP_W-1:0]     opcode_i,
  input  logic [tcw_pkg::CHAR_W-1:0]   char_code_i,
  input  logic [tcw_pkg::RD_ROW_W-1:0] read_row_i,
  input  logic [tcw_pkg::RD_COL_W-1:0] read_col_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [4:0]                   cursor_row_out_o,
  output logic [6:0]                   cursor_col_out_o,
  output logic [tcw_pkg::CHAR_W-1:0]   cell_char_o,
  output logic [tcw_pkg::ATTR_W-1:0]   cell_attr_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [tcw_pkg::IDX_W-1:0]    cfg_index_i,
  input  logic [tcw_pkg::COLOR_W-1:0]  cfg_data_i
);
  import tcw_pkg::*;

  localparam int NCELLS = ROWS * COLS;
  localparam int AW = $clog2(NCELLS);

  logic [COLOR_W-1:0] fg_q, bg_q;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr, mem_raddr;
  logic [CELL_W-1:0]  mem_wdata, mem_rdata;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fg_q <= FG_RESET;
      bg_q <= BG_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_FG:  fg_q <= cfg_data_i;
        REG_BG:  bg_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  tcw_ctrl #(
    .COLS (COLS),
    .ROWS (ROWS),
    .AW   (AW)
  ) u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .attr_i           ({bg_q, fg_q}),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .opcode_i         (opcode_i),
    .char_code_i      (char_code_i),
    .read_row_i       (read_row_i),
    .read_col_i       (read_col_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .cursor_row_out_o (cursor_row_out_o),
    .cursor_col_out_o (cursor_col_out_o),
    .cell_char_o      (cell_char_o),
    .cell_attr_o      (cell_attr_o),
    .mem_we_o         (mem_we),
    .mem_waddr_o      (mem_waddr),
    .mem_wdata_o      (mem_wdata),
    .mem_raddr_o      (mem_raddr),
    .mem_rdata_i      (mem_rdata)
  );

  tcw_cell_mem #(
    .DEPTH (NCELLS),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule
